[hdl/hcbp_pkg.sv]
package hcbp_pkg;

    // Table geometry
    localparam int NUM_SYMBOLS  = 128;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_AW       = $clog2(NUM_SYMBOLS);
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);

    // Input field widths
    localparam int OP_W      = 2;
    localparam int SYMBOL_W  = 7;
    localparam int CLEN_W    = 6;
    localparam int CBITS_W   = 32;

    // Packer widths
    localparam int BYTE_W    = 8;
    localparam int VBITS_W   = 4;
    localparam int PEND_W    = BYTE_W - 1;
    localparam int PCNT_W    = 3;
    localparam int ACC_W     = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W     = $clog2(ACC_W + 1);

    localparam logic [VBITS_W-1:0] FULL_BYTE_BITS = VBITS_W'(BYTE_W);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic table_write;
        logic table_read;
        logic load_acc;
        logic emit_byte;
        logic finish;
        logic emit_flush;
    } hcbp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sym_in_range;
        logic has_byte;
        logic last_byte;
        logic out_free;
    } hcbp_stat_t;

endpackage

[hdl/hcbp_ctrl.sv]
module hcbp_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [hcbp_pkg::OP_W-1:0] operation,
    output logic                     item_ready,
    output hcbp_pkg::hcbp_cmd_t      cmd,
    input  hcbp_pkg::hcbp_stat_t     stat
);
    import hcbp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // Sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.table_write = stat.sym_in_range;
                    end
                    else if (operation == OP_ENCODE)
                    begin
                        if (stat.sym_in_range)
                        begin
                            cmd.table_read = 1'b1;
                            state_next     = S_READ;
                        end
                    end
                    else if (operation == OP_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_READ:
            begin
                cmd.load_acc = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.has_byte)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (stat.last_byte)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_byte || cmd.emit_flush) |-> stat.out_free)
        else $error("byte pushed while output register is full");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.table_read |=> cmd.load_acc)
        else $error("table read not followed by accumulator load");

    a_load_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_acc |=> (state_reg == S_EMIT))
        else $error("accumulator load not followed by emit phase");

endmodule

[hdl/hcbp_datapath.sv]
module hcbp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [hcbp_pkg::SYMBOL_W-1:0]  symbol,
    input  logic [hcbp_pkg::CLEN_W-1:0]    code_length,
    input  logic [hcbp_pkg::CBITS_W-1:0]   code_bits,
    input  hcbp_pkg::hcbp_cmd_t            cmd,
    output hcbp_pkg::hcbp_stat_t           stat,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]    out_byte,
    output logic [hcbp_pkg::VBITS_W-1:0]   valid_bits,
    output logic                           last_of_run,
    output logic                           stream_end
);
    import hcbp_pkg::*;

    // Code table: memory plus per-entry valid flags (unwritten entries read length zero)
    logic [LEN_W-1:0]        len_mem  [NUM_SYMBOLS];
    logic [MAX_CODE_LEN-1:0] code_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  entry_valid_reg;

    logic [SYM_AW-1:0]       addr;
    logic [LEN_W-1:0]        len_sat;
    logic [MAX_CODE_LEN-1:0] code_ext;
    logic [MAX_CODE_LEN-1:0] code_mask;

    logic [LEN_W-1:0]        rd_len_reg;
    logic [MAX_CODE_LEN-1:0] rd_code_reg;
    logic                    rd_hit_reg;

    // Packer state
    logic [ACC_W-1:0]  acc_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [PEND_W-1:0] pending_bits_reg;
    logic [PCNT_W-1:0] pending_count_reg;

    logic [ACC_W-1:0]  acc_load;
    logic [TOT_W-1:0]  total_load;
    logic [ACC_W-1:0]  acc_shift;
    logic [TOT_W-1:0]  total_sub;

    // Output register
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [VBITS_W-1:0]  valid_bits_reg;
    logic                last_reg;
    logic                end_reg;
    logic                push;

    assign addr = SYM_AW'(symbol);

    // Saturate length and drop stray code bits
    always_comb
    begin
        if (int'(code_length) > MAX_CODE_LEN)
        begin
            len_sat = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            len_sat = LEN_W'(code_length);
        end
        code_ext = MAX_CODE_LEN'(code_bits);
        for (int i = 0; i < MAX_CODE_LEN; i++)
        begin
            code_mask[i] = code_ext[i] && (i < int'(len_sat));
        end
    end

    // Write and read the table memory
    always_ff @(posedge clk)
    begin
        if (cmd.table_write)
        begin
            len_mem[addr]  <= len_sat;
            code_mem[addr] <= code_mask;
        end
        if (cmd.table_read)
        begin
            rd_len_reg  <= len_mem[addr];
            rd_code_reg <= code_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.table_write)
            begin
                entry_valid_reg[addr] <= 1'b1;
            end
            if (cmd.table_read)
            begin
                rd_hit_reg <= entry_valid_reg[addr];
            end
        end
    end

    // Merge the code word behind the pending bits
    always_comb
    begin
        if (rd_hit_reg)
        begin
            acc_load   = ACC_W'(pending_bits_reg) | (ACC_W'(rd_code_reg) << pending_count_reg);
            total_load = TOT_W'(pending_count_reg) + TOT_W'(rd_len_reg);
        end
        else
        begin
            acc_load   = ACC_W'(pending_bits_reg);
            total_load = TOT_W'(pending_count_reg);
        end
        acc_shift = acc_reg >> BYTE_W;
        total_sub = total_reg - TOT_W'(BYTE_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg           <= '0;
            total_reg         <= '0;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
        end
        else
        begin
            if (cmd.load_acc)
            begin
                acc_reg   <= acc_load;
                total_reg <= total_load;
            end
            else if (cmd.emit_byte)
            begin
                acc_reg   <= acc_shift;
                total_reg <= total_sub;
            end
            // Keep leftover bits for the next symbol
            if (cmd.finish)
            begin
                if (cmd.emit_byte)
                begin
                    pending_bits_reg  <= acc_shift[PEND_W-1:0];
                    pending_count_reg <= total_sub[PCNT_W-1:0];
                end
                else
                begin
                    pending_bits_reg  <= acc_reg[PEND_W-1:0];
                    pending_count_reg <= total_reg[PCNT_W-1:0];
                end
            end
            else if (cmd.emit_flush)
            begin
                pending_bits_reg  <= '0;
                pending_count_reg <= '0;
            end
        end
    end

    // Output register: hold a byte until the consumer takes it
    assign push = cmd.emit_byte || cmd.emit_flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_byte)
        begin
            out_byte_reg   <= acc_reg[BYTE_W-1:0];
            valid_bits_reg <= FULL_BYTE_BITS;
            last_reg       <= stat.last_byte;
            end_reg        <= 1'b0;
        end
        else if (cmd.emit_flush)
        begin
            out_byte_reg   <= BYTE_W'(pending_bits_reg);
            valid_bits_reg <= VBITS_W'(pending_count_reg);
            last_reg       <= 1'b1;
            end_reg        <= 1'b1;
        end
    end

    assign stat.sym_in_range = (int'(symbol) < NUM_SYMBOLS);
    assign stat.has_byte     = (total_reg >= TOT_W'(BYTE_W));
    assign stat.last_byte    = (total_reg < TOT_W'(2 * BYTE_W));
    assign stat.out_free     = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign valid_bits   = valid_bits_reg;
    assign last_of_run  = last_reg;
    assign stream_end   = end_reg;

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("pushed byte not presented");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_flush |=> (pending_count_reg == '0) && (pending_bits_reg == '0))
        else $error("flush left pending bits");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_acc |=> (int'(total_reg) <= ACC_W))
        else $error("bit total exceeds accumulator");

endmodule

[hdl/huffman_code_bit_packer.sv]
// Channel   Handshake                    Payload
// item      item_valid / item_ready      operation, symbol, code_length, code_bits
// result    result_valid / result_ready  out_byte, valid_bits, last_of_run, stream_end
//
// A load completes when accepted. An encode steps through accept, table memory
// read, accumulator load, then one byte per cycle from the packer shift while the
// output register is free. A flush accepts, then emits the pending bits.
// Reset clears the table valid flags, so every symbol starts with length zero.
// A full output register stalls byte emission; a new request is taken while the
// last result still waits.
module huffman_code_bit_packer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [hcbp_pkg::OP_W-1:0]           operation,
    input  logic [hcbp_pkg::SYMBOL_W-1:0]       symbol,
    input  logic [hcbp_pkg::CLEN_W-1:0]         code_length,
    input  logic [hcbp_pkg::CBITS_W-1:0]        code_bits,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]         out_byte,
    output logic [hcbp_pkg::VBITS_W-1:0]        valid_bits,
    output logic                                last_of_run,
    output logic                                stream_end
);
    import hcbp_pkg::*;

    hcbp_cmd_t  cmd;
    hcbp_stat_t stat;

    hcbp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (operation),
        .item_ready (item_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    hcbp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (symbol),
        .code_length  (code_length),
        .code_bits    (code_bits),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .valid_bits   (valid_bits),
        .last_of_run  (last_of_run),
        .stream_end   (stream_end)
    );

endmodule
